### hw/rtl/ipq_pkg.sv
// Shared constants and types for the indexed priority queue.
// No dependencies; imported by indexed_priority_queue and its testbench.
package ipq_pkg;

   // Queue geometry
   localparam int ID_COUNT = 64;
   localparam int IDX_W    = $clog2(ID_COUNT);
   localparam int CNT_W    = $clog2(ID_COUNT + 1);

   // Field widths
   localparam int CMD_W    = 3;
   localparam int REQ_ID_W = 8;
   localparam int PRIO_W   = 32;
   localparam int LIMIT_W  = 7;

   // Stream word widths (padded to whole bytes)
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_PAD_W  = RSP_DATA_W - 1 - IDX_W - PRIO_W - CNT_W;

   // Id limit after reset
   localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(64);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INC    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DEC    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

   typedef logic signed [PRIO_W-1:0] prio_type;

endpackage

### hw/rtl/indexed_priority_queue.sv
// Query and rejected commands go from lookup to the result word. Pop walks the
// whole list (one ordered-list read per entry); insert walks down from the tail
// to its slot; a priority change walks the list, then walks down to its slot.
// One command at a time; tready is high only between commands, and a result
// word that is not taken holds the block in its done state. Throughput is set
// by the single ordered-list port. Reset: synchronous; clears presence bits,
// entry count, id limit (to 64). List and priority memories are not cleared.
module indexed_priority_queue (
   input  logic                             clock,
   input  logic                             reset,
   // Request: tuser = cmd[2:0]; tdata = id[7:0], priority_req[39:8]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ipq_pkg::CMD_W-1:0]        req_tuser,
   input  logic [ipq_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Response: tdata = ok[0], out_id[6:1], out_priority[38:7],
   //           entry_count[45:39], zero[47:46]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ipq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Id limit register
   input  logic                             csr_we,
   input  logic [ipq_pkg::LIMIT_W-1:0]      csr_wdata
);
   import ipq_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOOKUP = 6'b000010,
      ST_DEL    = 6'b000100,
      ST_INS    = 6'b001000,
      ST_PLACE  = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   // Control state
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    held_ff, held_in;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [ID_COUNT-1:0] present_ff;
   logic                found_ff, found_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Command payload
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [IDX_W-1:0]    id_ff, id_in;
   logic                idv_ff, idv_in;
   logic                pres_ff, pres_in;
   prio_type            pr_ff, pr_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [IDX_W-1:0]    place_ff, place_in;
   logic [IDX_W-1:0]    rem_id_ff, rem_id_in;
   prio_type            rem_prio_ff, rem_prio_in;
   logic                res_ok_ff, res_ok_in;
   logic [IDX_W-1:0]    res_id_ff, res_id_in;
   prio_type            res_prio_ff, res_prio_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Memories: ordered list (id and priority by position), priority by id
   logic [IDX_W-1:0]    ord_id_mem   [ID_COUNT];
   prio_type            ord_prio_mem [ID_COUNT];
   prio_type            prio_mem     [ID_COUNT];
   logic [IDX_W-1:0]    ord_rd_id;
   prio_type            ord_rd_prio;
   prio_type            prio_rd;

   logic                ord_we;
   logic [IDX_W-1:0]    ord_waddr, ord_wid, ord_raddr, prio_raddr;
   prio_type            ord_wprio;
   logic                prio_we;
   logic                set_present, clr_present;
   logic [IDX_W-1:0]    clr_idx;

   // Request field unpack
   logic [REQ_ID_W-1:0] req_id;
   prio_type            req_pr;
   logic                accept;
   logic [CNT_W-1:0]    held_m1, held_m2, pos_p1;
   logic                match, last;
   logic [IDX_W-1:0]    rem_id_now;
   prio_type            rem_prio_now;

   assign req_id     = req_tdata[REQ_ID_W-1:0];
   assign req_pr     = req_tdata[REQ_ID_W +: PRIO_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign held_m1 = held_ff - CNT_W'(1);
   assign held_m2 = held_ff - CNT_W'(2);
   assign pos_p1  = CNT_W'(pos_ff) + CNT_W'(1);

   // Removal pass: match on position zero for pop, on id otherwise
   assign match        = (cmd_ff == CMD_POP) ? (pos_ff == '0) : (ord_rd_id == id_ff);
   assign last         = (pos_p1 >= held_ff);
   assign rem_id_now   = (match && !found_ff) ? ord_rd_id   : rem_id_ff;
   assign rem_prio_now = (match && !found_ff) ? ord_rd_prio : rem_prio_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      idv_in       = idv_ff;
      pres_in      = pres_ff;
      pr_in        = pr_ff;
      pos_in       = pos_ff;
      place_in     = place_ff;
      rem_id_in    = rem_id_ff;
      rem_prio_in  = rem_prio_ff;
      res_ok_in    = res_ok_ff;
      res_id_in    = res_id_ff;
      res_prio_in  = res_prio_ff;
      rsp_data_in  = rsp_data_ff;
      ord_we       = 1'b0;
      ord_waddr    = pos_ff;
      ord_wid      = id_ff;
      ord_wprio    = pr_ff;
      ord_raddr    = pos_ff;
      prio_raddr   = req_id[IDX_W-1:0];
      prio_we      = 1'b0;
      set_present  = 1'b0;
      clr_present  = 1'b0;
      clr_idx      = rem_id_now;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in      = req_tuser;
               id_in       = req_id[IDX_W-1:0];
               idv_in      = (req_id < REQ_ID_W'(limit_ff)) &&
                             (32'(req_id) < 32'(ID_COUNT));
               pres_in     = present_ff[req_id[IDX_W-1:0]];
               pr_in       = req_pr;
               res_ok_in   = 1'b0;
               res_id_in   = '0;
               res_prio_in = '0;
               state_in    = ST_LOOKUP;
            end
         end

         ST_LOOKUP: begin
            state_in = ST_DONE;
            found_in = 1'b0;
            pos_in   = '0;
            ord_raddr = '0;
            case (cmd_ff) inside
               CMD_INSERT: begin
                  if (idv_ff && !pres_ff && (held_ff < CNT_W'(ID_COUNT))) begin
                     if (held_ff == '0) begin
                        place_in = '0;
                        state_in = ST_PLACE;
                     end else begin
                        ord_raddr = held_m1[IDX_W-1:0];
                        pos_in    = held_m1[IDX_W-1:0];
                        state_in  = ST_INS;
                     end
                  end
               end
               CMD_INC, CMD_DEC: begin
                  if (idv_ff && pres_ff &&
                      ((cmd_ff == CMD_INC) ? (pr_ff > prio_rd) : (pr_ff < prio_rd)))
                     state_in = ST_DEL;
               end
               CMD_POP: begin
                  if (held_ff != '0)
                     state_in = ST_DEL;
               end
               CMD_QUERY: begin
                  if (idv_ff && pres_ff) begin
                     res_ok_in   = 1'b1;
                     res_prio_in = prio_rd;
                  end
               end
               default: ;
            endcase
         end

         // Walk up the list, closing the gap behind the removed entry
         ST_DEL: begin
            if (found_ff) begin
               ord_we    = 1'b1;
               ord_waddr = pos_ff - IDX_W'(1);
               ord_wid   = ord_rd_id;
               ord_wprio = ord_rd_prio;
            end
            if (match && !found_ff) begin
               found_in    = 1'b1;
               rem_id_in   = ord_rd_id;
               rem_prio_in = ord_rd_prio;
            end
            if (!last) begin
               pos_in    = pos_ff + IDX_W'(1);
               ord_raddr = pos_ff + IDX_W'(1);
            end else begin
               held_in = held_m1;
               if (cmd_ff == CMD_POP) begin
                  clr_present = 1'b1;
                  res_ok_in   = 1'b1;
                  res_id_in   = rem_id_now;
                  res_prio_in = rem_prio_now;
                  state_in    = ST_DONE;
               end else if (held_m1 == '0) begin
                  place_in = '0;
                  state_in = ST_PLACE;
               end else begin
                  ord_raddr = held_m2[IDX_W-1:0];
                  pos_in    = held_m2[IDX_W-1:0];
                  state_in  = ST_INS;
               end
            end
         end

         // Walk down the list, moving lower-or-equal entries back one slot
         ST_INS: begin
            ord_we    = 1'b1;
            ord_waddr = pos_ff + IDX_W'(1);
            if (ord_rd_prio <= pr_ff) begin
               ord_wid   = ord_rd_id;
               ord_wprio = ord_rd_prio;
               if (pos_ff == '0) begin
                  place_in = '0;
                  state_in = ST_PLACE;
               end else begin
                  pos_in    = pos_ff - IDX_W'(1);
                  ord_raddr = pos_ff - IDX_W'(1);
               end
            end else begin
               prio_we     = 1'b1;
               held_in     = held_ff + CNT_W'(1);
               set_present = 1'b1;
               res_ok_in   = 1'b1;
               state_in    = ST_DONE;
            end
         end

         ST_PLACE: begin
            ord_we      = 1'b1;
            ord_waddr   = place_ff;
            prio_we     = 1'b1;
            held_in     = held_ff + CNT_W'(1);
            set_present = 1'b1;
            res_ok_in   = 1'b1;
            state_in    = ST_DONE;
         end

         // Hand the result word to the output register
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {RSP_PAD_W'(0), held_ff, res_prio_ff, res_id_ff, res_ok_ff};
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         limit_ff     <= LIMIT_RST;
         present_ff   <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we)
            limit_ff <= csr_wdata;
         if (set_present)
            present_ff[id_ff] <= 1'b1;
         if (clr_present)
            present_ff[clr_idx] <= 1'b0;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      idv_ff      <= idv_in;
      pres_ff     <= pres_in;
      pr_ff       <= pr_in;
      pos_ff      <= pos_in;
      place_ff    <= place_in;
      rem_id_ff   <= rem_id_in;
      rem_prio_ff <= rem_prio_in;
      res_ok_ff   <= res_ok_in;
      res_id_ff   <= res_id_in;
      res_prio_ff <= res_prio_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Ordered list memory, write-first on a same-address read
   always_ff @(posedge clock) begin
      if (ord_we) begin
         ord_id_mem[ord_waddr]   <= ord_wid;
         ord_prio_mem[ord_waddr] <= ord_wprio;
      end
      if (ord_we && (ord_waddr == ord_raddr)) begin
         ord_rd_id   <= ord_wid;
         ord_rd_prio <= ord_wprio;
      end else begin
         ord_rd_id   <= ord_id_mem[ord_raddr];
         ord_rd_prio <= ord_prio_mem[ord_raddr];
      end
   end

   // Priority-by-id memory
   always_ff @(posedge clock) begin
      if (prio_we)
         prio_mem[id_ff] <= pr_ff;
      prio_rd <= prio_mem[prio_raddr];
   end

endmodule

### tb/tb_indexed_priority_queue.sv
// Self-checking testbench for indexed_priority_queue: a directed word list, then random
// command phases under several id limits, checked against a sorted-list queue model.
// Depends on ipq_pkg and the indexed_priority_queue RTL.
module tb_indexed_priority_queue;
   import ipq_pkg::*;

   localparam int          CYCLE_LIMIT   = 3_000_000;
   localparam int          CALM_FIRST    = 500;
   localparam int          CALM_LAST     = 650;
   localparam logic [CMD_W-1:0] CMD_BAD_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_BAD_LAST  = 3'd7;
   localparam prio_type    PRIO_MIN      = 32'sh8000_0000;
   localparam prio_type    PRIO_MAX      = 32'sh7FFF_FFFF;

   typedef struct {
      logic              ok;
      logic [IDX_W-1:0]  out_id;
      prio_type          out_priority;
      logic [CNT_W-1:0]  entry_count;
   } queue_result_type;

   // Queue model plus the store of expected response words
   class ipq_scoreboard;
      logic [IDX_W-1:0] order_q[$];   // ids, highest priority first
      prio_type         prio_of[ID_COUNT];
      bit               held[ID_COUNT];
      int unsigned      id_limit = 64;
      queue_result_type expected[$];
      int               errors = 0;

      function bit id_ok(logic [REQ_ID_W-1:0] id);
         return id < id_limit && id < ID_COUNT;
      endfunction

      // new entry goes ahead of the first one with priority <= its own
      function void place(logic [IDX_W-1:0] id, prio_type pr);
         int pos;
         pos = order_q.size();
         for (int i = 0; i < order_q.size(); i++) begin
            if (prio_of[order_q[i]] <= pr) begin
               pos = i;
               break;
            end
         end
         order_q.insert(pos, id);
         prio_of[id] = pr;
      endfunction

      function void unlink(logic [IDX_W-1:0] id);
         for (int i = 0; i < order_q.size(); i++) begin
            if (order_q[i] == id) begin
               order_q.delete(i);
               break;
            end
         end
      endfunction

      // update the model for an accepted request word and queue its response
      function void note_request(logic [CMD_W-1:0] cmd, logic [REQ_ID_W-1:0] id,
                                 prio_type pr);
         queue_result_type r;
         logic [IDX_W-1:0] top;
         bit strict;
         r = '{ok: 1'b0, out_id: '0, out_priority: '0, entry_count: '0};
         case (cmd) inside
            CMD_INSERT: begin
               if (id_ok(id) && !held[id] && order_q.size() < ID_COUNT) begin
                  place(id[IDX_W-1:0], pr);
                  held[id] = 1'b1;
                  r.ok = 1'b1;
               end
            end
            CMD_INC, CMD_DEC: begin
               if (id_ok(id) && held[id]) begin
                  strict = (cmd == CMD_INC) ? (pr > prio_of[id]) : (pr < prio_of[id]);
                  if (strict) begin
                     unlink(id[IDX_W-1:0]);
                     place(id[IDX_W-1:0], pr);
                     r.ok = 1'b1;
                  end
               end
            end
            CMD_POP: begin
               if (order_q.size() > 0) begin
                  top = order_q.pop_front();
                  held[top] = 1'b0;
                  r.out_id = top;
                  r.out_priority = prio_of[top];
                  r.ok = 1'b1;
               end
            end
            CMD_QUERY: begin
               if (id_ok(id) && held[id]) begin
                  r.out_priority = prio_of[id];
                  r.ok = 1'b1;
               end
            end
            default: ;
         endcase
         r.entry_count = CNT_W'(order_q.size());
         expected.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      // response word: ok[0], out_id[6:1], out_priority[38:7], entry_count[45:39]
      function void check_response(logic [RSP_DATA_W-1:0] word);
         queue_result_type e;
         if (expected.size() == 0) begin
            $display("%0t: response word %h with none expected", $time, word);
            errors++;
            return;
         end
         e = expected.pop_front();
         compare_field("ok", 32'(e.ok), 32'(word[0]));
         compare_field("out_id", 32'(e.out_id), 32'(word[6:1]));
         compare_field("out_priority", e.out_priority, word[38:7]);
         compare_field("entry_count", 32'(e.entry_count), 32'(word[45:39]));
         compare_field("padding", 32'd0, 32'(word[47:46]));
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [CMD_W-1:0]       req_tuser  = '0;     // cmd[2:0]
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;     // id[7:0], priority_req[39:8]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;           // ok, out_id, out_priority, entry_count
   logic                   csr_we     = 1'b0;
   logic [LIMIT_W-1:0]     csr_wdata  = '0;

   ipq_scoreboard sb;
   bit            calm = 1'b0;   // no idling on either side while set
   int            cycles = 0;
   int            item_no = 0;
   int            phase_limit[7] = '{127, 1, 0, 64, 37, 2, 64};
   int            phase_items[7] = '{300, 100, 60, 380, 300, 80, 380};

   indexed_priority_queue DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // cycle count and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("indexed_priority_queue verification failed");
         $finish;
      end
   end

   // response side back-pressure
   always @(negedge clock) begin
      rsp_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 11);
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
   end

   // Entered and left at a falling edge; holds the word until it is taken.
   task automatic send_request(logic [CMD_W-1:0] cmd, logic [REQ_ID_W-1:0] id,
                               prio_type pr);
      if (!calm) begin
         while ($urandom_range(0, 99) < 11) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {pr, id};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, id, pr);
      @(negedge clock);
   endtask

   // Limit writes only once the block has drained
   task automatic write_id_limit(int unsigned value);
      req_tvalid <= 1'b0;
      while (sb.expected.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= LIMIT_W'(value);
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.id_limit = value;
   endtask

   // One random command, mostly well formed against the current queue contents
   task automatic random_request(int ins_w, int pop_w);
      int r, lim, k;
      longint v;
      logic [CMD_W-1:0] cmd;
      logic [REQ_ID_W-1:0] id;
      prio_type pr;
      r = $urandom_range(0, 99);
      if (r < ins_w)                   cmd = CMD_INSERT;
      else if (r < ins_w + pop_w)      cmd = CMD_POP;
      else if (r < ins_w + pop_w + 15) cmd = CMD_INC;
      else if (r < ins_w + pop_w + 30) cmd = CMD_DEC;
      else if (r < ins_w + pop_w + 42) cmd = CMD_QUERY;
      else                             cmd = CMD_W'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));

      // id: a held one for changes and queries, a free-range one for inserts, some noise
      lim = (sb.id_limit < ID_COUNT) ? sb.id_limit : ID_COUNT;
      if (lim == 0 || $urandom_range(0, 9) == 0)
         id = REQ_ID_W'($urandom_range(0, 255));
      else if (cmd == CMD_INSERT || sb.order_q.size() == 0)
         id = REQ_ID_W'($urandom_range(0, lim - 1));
      else
         id = REQ_ID_W'(sb.order_q[$urandom_range(0, sb.order_q.size() - 1)]);

      // priority: extremes, a small tie-prone set, or anything
      k = $urandom_range(0, 9);
      case (k)
         0:       pr = PRIO_MIN;
         1:       pr = PRIO_MAX;
         2:       pr = $urandom_range(0, 1) ? prio_type'(0) : prio_type'(-1);
         3, 4, 5: pr = prio_type'((int'($urandom_range(0, 7)) - 4) * 65536);
         default: pr = prio_type'($urandom);
      endcase

      // strict change from the held priority most of the time, clamped at the ends
      if ((cmd == CMD_INC || cmd == CMD_DEC) && id < ID_COUNT && sb.held[id]
          && $urandom_range(0, 9) < 8) begin
         v = longint'(sb.prio_of[id]);
         if (cmd == CMD_INC) v = v + longint'($urandom_range(1, 1 << 20));
         else                v = v - longint'($urandom_range(1, 1 << 20));
         if (v > longint'(PRIO_MAX)) v = longint'(PRIO_MAX);
         if (v < longint'(PRIO_MIN)) v = longint'(PRIO_MIN);
         pr = prio_type'(v);
      end
      send_request(cmd, id, pr);
   endtask

   initial begin
      sb = new();
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words at the reset limit
      send_request(CMD_POP,    8'd0,   32'sd0);          // empty pop
      send_request(CMD_QUERY,  8'd5,   32'sd0);          // query of absent id
      send_request(CMD_INC,    8'd5,   32'sd100);        // change of absent id
      send_request(CMD_INSERT, 8'd0,   PRIO_MIN);
      send_request(CMD_INSERT, 8'd63,  PRIO_MAX);
      send_request(CMD_INSERT, 8'd10,  32'sd0);
      send_request(CMD_INSERT, 8'd11,  32'sd0);          // tie, newest first
      send_request(CMD_INSERT, 8'd63,  32'sd7);          // already held
      send_request(CMD_INSERT, 8'd64,  32'sd7);          // id out of range
      send_request(CMD_INSERT, 8'd255, 32'sh1234_5678);  // id out of range
      send_request(CMD_QUERY,  8'd10,  32'sd0);
      send_request(CMD_INC,    8'd10,  32'sd0);          // not strictly greater
      send_request(CMD_INC,    8'd10,  32'sh0005_0000);
      send_request(CMD_DEC,    8'd11,  32'sd0);          // not strictly less
      send_request(CMD_DEC,    8'd11,  -32'sd1);
      send_request(CMD_DEC,    8'd63,  PRIO_MIN);        // ties with id 0
      send_request(CMD_BAD_FIRST, 8'd1, 32'sd0);
      send_request(CMD_BAD_FIRST + 3'd1, 8'd10, 32'sd0);
      send_request(CMD_BAD_LAST, 8'd255, PRIO_MAX);
      send_request(CMD_QUERY,  8'd63,  32'sd0);
      repeat (5) send_request(CMD_POP, 8'd0, 32'sd0);   // drain, last one empty

      // random phases: fill-heavy first half, drain-heavy second half
      for (int p = 0; p < 7; p++) begin
         write_id_limit(phase_limit[p]);
         for (int n = 0; n < phase_items[p]; n++) begin
            calm = (item_no >= CALM_FIRST && item_no < CALM_LAST);
            if (n < phase_items[p] / 2) random_request(45, 10);
            else                        random_request(20, 35);
            item_no++;
         end
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      while (sb.expected.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (sb.errors == 0)
         $display("indexed_priority_queue verification clean");
      else
         $display("indexed_priority_queue verification failed");
      $finish;
   end

endmodule
